[rtl/core/pip_pkg.sv]
// Package for the point-in-polygon crossing-number block.
// Vertex type, datapath widths and sequencer codes; no dependencies.
`default_nettype none

package pip_pkg;

    // Coordinate and register widths
    localparam int COORD_W = 16;
    localparam int CNT_W   = 7;
    localparam int IDX_W   = 6;

    // Edge datapath: 18-bit signed operands, 36-bit signed products
    localparam int OP_W   = COORD_W + 2;
    localparam int PROD_W = 2 * OP_W;

    // Sequencer state codes
    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    // Function codes of an input transaction
    localparam logic FUNC_WRITE = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;

    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
    } vertex_t;

    typedef logic signed [OP_W-1:0]   op_t;
    typedef logic signed [PROD_W-1:0] prod_t;

endpackage

`default_nettype wire

[rtl/core/point_in_polygon_test.sv]
// Point-in-polygon test (even-odd crossing number); uses pip_pkg.
// Vertex write: no result; the next transaction can be taken the cycle after.
// Query, n = min(vertex_count, MAX_VERTICES) of three or more: n+1 vertex RAM reads
// feed a 3-stage edge pipeline; out_valid is registered once the pipeline drains, and
// in_stall stays high until the result has been loaded into the output register.
// Query with n below three: no reads, result 0. Reset clears control and vertex_count, not the RAM.
`default_nettype none

module point_in_polygon_test #(
    parameter int MAX_VERTICES = 64
) (
    input  wire                           clk,
    input  wire                           rst_n,
    // configuration
    input  wire                           cfg_we,
    input  wire  [pip_pkg::CNT_W-1:0]     cfg_wdata,
    // input channel
    input  wire                           in_valid,
    output logic                          in_stall,
    input  wire                           func,
    input  wire  [pip_pkg::IDX_W-1:0]     vertex_index,
    input  wire  [pip_pkg::COORD_W-1:0]   coord_x,
    input  wire  [pip_pkg::COORD_W-1:0]   coord_y,
    // output channel
    output logic                          out_valid,
    input  wire                           out_stall,
    output logic                          inside_res
);
    import pip_pkg::*;

    localparam int AW = $clog2(MAX_VERTICES);
    localparam int CW = $clog2(MAX_VERTICES + 1);
    localparam int NW = (CW > CNT_W) ? CW : CNT_W;
    localparam int IW = (CW > IDX_W) ? CW : IDX_W;

    // Configuration register
    logic [CNT_W-1:0] vcount_reg;

    // Sequencer and query registers
    logic [1:0]          state_reg;
    logic [CW-1:0]       rd_cnt_reg;
    logic                issue_done_reg;
    logic [COORD_W-1:0]  px_reg;
    logic [COORD_W-1:0]  py_reg;
    logic                parity_reg;

    // Vertex RAM
    vertex_t             vmem [MAX_VERTICES];
    vertex_t             rdata_reg;
    vertex_t             prev_reg;
    logic                rd_en;
    logic [AW-1:0]       rd_addr;
    logic                wr_en;

    // Pipeline valids
    logic                p1_valid_reg;
    logic                p1_edge_reg;
    logic                p2_valid_reg;
    logic                p3_valid_reg;

    // Stage 2 operands
    logic                s2_straddle_reg;
    op_t                 s2_dx_reg;
    op_t                 s2_dyn_reg;
    op_t                 s2_dena_reg;
    op_t                 s2_d_reg;

    // Stage 3 products
    logic                s3_straddle_reg;
    prod_t               s3_num_reg;
    prod_t               s3_m1_reg;
    prod_t               s3_m0_reg;

    // Output register
    logic                out_valid_reg;
    logic                inside_res_reg;

    logic                in_acc;
    logic                query_acc;
    logic [NW-1:0]       vc_ext;
    logic [CW-1:0]       n;
    logic                pipe_busy;
    logic                out_load;

    // Effective vertex count, saturated to the RAM depth
    assign vc_ext = NW'(vcount_reg);
    always_comb
    begin
        if (vc_ext > NW'(MAX_VERTICES))
            n = CW'(MAX_VERTICES);
        else
            n = vc_ext[CW-1:0];
    end

    // Handshake
    assign in_stall  = (state_reg != ST_IDLE);
    assign in_acc    = in_valid && !in_stall;
    assign query_acc = in_acc && (func == FUNC_QUERY);
    assign wr_en     = in_acc && (func == FUNC_WRITE)
                       && (IW'(vertex_index) < IW'(MAX_VERTICES));

    assign pipe_busy = p1_valid_reg || p2_valid_reg || p3_valid_reg;
    assign out_load  = (state_reg == ST_DONE) && (!out_valid_reg || !out_stall);

    // Read address: vertices 0..n-1, then vertex 0 again to close the polygon
    assign rd_en   = (state_reg == ST_RUN) && !issue_done_reg;
    assign rd_addr = (rd_cnt_reg == n) ? '0 : rd_cnt_reg[AW-1:0];

    // Configuration write
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vcount_reg <= '0;
        else if (cfg_we)
            vcount_reg <= cfg_wdata;
    end

    // Vertex RAM, one write and one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
            vmem[AW'(vertex_index)] <= '{x: coord_x, y: coord_y};
        if (rd_en)
            rdata_reg <= vmem[rd_addr];
    end

    // Sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            rd_cnt_reg     <= '0;
            issue_done_reg <= 1'b0;
        end
        else
        begin
            case (state_reg)
                ST_IDLE:
                begin
                    if (query_acc)
                    begin
                        rd_cnt_reg     <= '0;
                        issue_done_reg <= 1'b0;
                        state_reg      <= (n < CW'(3)) ? ST_DONE : ST_RUN;
                    end
                end
                ST_RUN:
                begin
                    if (!issue_done_reg)
                    begin
                        rd_cnt_reg <= rd_cnt_reg + CW'(1);
                        if (rd_cnt_reg == n)
                            issue_done_reg <= 1'b1;
                    end
                    else if (!pipe_busy)
                        state_reg <= ST_DONE;
                end
                ST_DONE:
                begin
                    if (out_load)
                        state_reg <= ST_IDLE;
                end
                default:
                    state_reg <= ST_IDLE;
            endcase
        end
    end

    // Query point capture
    always_ff @(posedge clk)
    begin
        if (query_acc)
        begin
            px_reg <= coord_x;
            py_reg <= coord_y;
        end
    end

    // Pipeline valids; first read only primes the previous vertex
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_valid_reg <= 1'b0;
            p1_edge_reg  <= 1'b0;
            p2_valid_reg <= 1'b0;
            p3_valid_reg <= 1'b0;
        end
        else
        begin
            p1_valid_reg <= rd_en;
            p1_edge_reg  <= rd_en && (rd_cnt_reg != '0);
            p2_valid_reg <= p1_valid_reg && p1_edge_reg;
            p3_valid_reg <= p2_valid_reg;
        end
    end

    // Stage 1: edge setup from previous and current vertex
    logic  s1_straddle;
    logic  s1_neg;
    op_t   s1_ax, s1_ay, s1_bx, s1_by, s1_px, s1_py;
    op_t   s1_den, s1_dyp;

    always_comb
    begin
        s1_ax  = op_t'({2'b00, prev_reg.x});
        s1_ay  = op_t'({2'b00, prev_reg.y});
        s1_bx  = op_t'({2'b00, rdata_reg.x});
        s1_by  = op_t'({2'b00, rdata_reg.y});
        s1_px  = op_t'({2'b00, px_reg});
        s1_py  = op_t'({2'b00, py_reg});
        s1_straddle = ((prev_reg.y > py_reg) && (rdata_reg.y < py_reg))
                   || ((prev_reg.y < py_reg) && (rdata_reg.y > py_reg));
        s1_neg = (rdata_reg.y < prev_reg.y);
        s1_den = s1_by - s1_ay;
        s1_dyp = s1_py - s1_ay;
    end

    always_ff @(posedge clk)
    begin
        if (p1_valid_reg)
        begin
            prev_reg        <= rdata_reg;
            s2_straddle_reg <= s1_straddle;
            s2_dx_reg       <= s1_bx - s1_ax;
            s2_d_reg        <= s1_px - s1_ax;
            // normalize so the denominator is positive
            s2_dyn_reg      <= s1_neg ? -s1_dyp : s1_dyp;
            s2_dena_reg     <= s1_neg ? -s1_den : s1_den;
        end
    end

    // Stage 2: numerator and the two scaled bounds
    always_ff @(posedge clk)
    begin
        if (p2_valid_reg)
        begin
            s3_straddle_reg <= s2_straddle_reg;
            s3_num_reg      <= s2_dx_reg * s2_dyn_reg;
            s3_m1_reg       <= (s2_d_reg + op_t'(1)) * s2_dena_reg;
            s3_m0_reg       <= s2_d_reg * s2_dena_reg;
        end
    end

    // Stage 3: px - ax < trunc(num/den) without a divider
    //   num >= 0: (d+1)*den <= num;  num < 0: d*den < num
    logic s3_cross;
    assign s3_cross = s3_straddle_reg &&
                      ((s3_num_reg >= 0) ? (s3_m1_reg <= s3_num_reg)
                                         : (s3_m0_reg < s3_num_reg));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            parity_reg <= 1'b0;
        else if (query_acc)
            parity_reg <= 1'b0;
        else if (p3_valid_reg && s3_cross)
            parity_reg <= !parity_reg;
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_load)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
            inside_res_reg <= parity_reg;
    end

    assign out_valid  = out_valid_reg;
    assign inside_res = inside_res_reg;

    // Assertions
    a_pipe_only_in_run: assert property (@(posedge clk) disable iff (!rst_n)
        (p2_valid_reg || p3_valid_reg) |-> (state_reg == ST_RUN))
        else $error("edge pipeline active outside a query");

    a_short_query: assert property (@(posedge clk) disable iff (!rst_n)
        (query_acc && (n < CW'(3))) |=> (state_reg == ST_DONE && !parity_reg))
        else $error("degenerate polygon query did not finish at once");

    a_rd_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RUN) |->
            ({1'b0, rd_cnt_reg} <= ({1'b0, n} + (CW+1)'(1))))
        else $error("read counter ran past the vertex count");

endmodule

`default_nettype wire
